### rtl/cdc_pkg.sv
// shared types, constants and table functions of the calendar date counter
`default_nettype none

package cdc_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned ORD_W   = 9;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned QUOT_W  = 7;
    localparam int unsigned PROD_W  = 27;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]   DEC_LAST    = 5'd31;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0]     DIV100_MUL   = 13'd5243;
    localparam int unsigned     DIV100_SHIFT = 19;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_NEXT  = 2'd1,
        CMD_PREV  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_DIV,
        ST_DATE,
        ST_ORD,
        ST_YY,
        ST_WDIV,
        ST_WSUM,
        ST_MOD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        AOP_YEAR,
        AOP_ORD,
        AOP_YY,
        AOP_WSUM
    } t_alu_op;

    // weekday sum terms, added or subtracted one per cycle after the adjusted year
    typedef enum logic [2:0] {
        TRM_QUART,
        TRM_CENT,
        TRM_QUAD,
        TRM_MONTH,
        TRM_DAY
    } t_term;

    typedef struct packed {
        logic    ord_done;
        logic    wsum_done;
    } t_stat;

    typedef struct packed {
        logic    in_ready;
        logic    out_valid;
        t_alu_op alu_op;
        logic    year_we;
        logic    div_we;
        logic    div_src_yy;
        logic    date_we;
        logic    ord_we;
        logic    yy_we;
        logic    wsum_init;
        logic    wsum_we;
        logic    wd_we;
    } t_ctrl;

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // (13 * mm + 8) / 5 with january and february counted as months 13 and 14
    function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        begin
            case (m)
                4'd1:    t = 6'd35;
                4'd2:    t = 6'd38;
                4'd3:    t = 6'd9;
                4'd4:    t = 6'd12;
                4'd5:    t = 6'd14;
                4'd6:    t = 6'd17;
                4'd7:    t = 6'd19;
                4'd8:    t = 6'd22;
                4'd9:    t = 6'd25;
                4'd10:   t = 6'd27;
                4'd11:   t = 6'd30;
                4'd12:   t = 6'd32;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/cdc_alu.sv
// shared add/subtract unit of the calendar date counter
`default_nettype none

module cdc_alu (
    input  wire logic [cdc_pkg::YEAR_W-1:0] i_a,
    input  wire logic [cdc_pkg::YEAR_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [cdc_pkg::YEAR_W-1:0] o_sum
);
    import cdc_pkg::*;

    always_comb begin
        if (i_sub) begin
            o_sum = i_a - i_b;
        end else begin
            o_sum = i_a + i_b;
        end
    end

endmodule

`default_nettype wire

### rtl/cdc_ctrl.sv
// sequencer of the calendar date counter
`default_nettype none

module cdc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_ready,
    input  wire cdc_pkg::t_stat i_stat,
    output cdc_pkg::t_ctrl      o_ctrl
);
    import cdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: n_state = ST_DIV;
            ST_DIV:  n_state = ST_DATE;
            ST_DATE: n_state = ST_ORD;
            ST_ORD: begin
                if (i_stat.ord_done) begin
                    n_state = ST_YY;
                end
            end
            ST_YY:   n_state = ST_WDIV;
            ST_WDIV: n_state = ST_WSUM;
            ST_WSUM: begin
                if (i_stat.wsum_done) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl            = '0;
        o_ctrl.alu_op     = AOP_WSUM;
        case (r_state)
            ST_IDLE: o_ctrl.in_ready = 1'b1;
            ST_YEAR: begin
                o_ctrl.alu_op  = AOP_YEAR;
                o_ctrl.year_we = 1'b1;
            end
            ST_DIV:  o_ctrl.div_we = 1'b1;
            ST_DATE: o_ctrl.date_we = 1'b1;
            ST_ORD: begin
                o_ctrl.alu_op = AOP_ORD;
                o_ctrl.ord_we = !i_stat.ord_done;
            end
            ST_YY: begin
                o_ctrl.alu_op = AOP_YY;
                o_ctrl.yy_we  = 1'b1;
            end
            ST_WDIV: begin
                o_ctrl.div_we     = 1'b1;
                o_ctrl.div_src_yy = 1'b1;
                o_ctrl.wsum_init  = 1'b1;
            end
            ST_WSUM: o_ctrl.wsum_we = 1'b1;
            ST_MOD:  o_ctrl.wd_we = 1'b1;
            ST_OUT:  o_ctrl.out_valid = 1'b1;
            default: o_ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/calendar_date_counter.sv
// top level of the gregorian calendar date counter
//
// holds one date (year, month, day), reset to 0001-01-01. each input request
// carries a command: load a date (clamped to a valid date), step one day
// forward, step one day back, or query. every request returns one result:
// the date after the command, its day of year and its day of week (0 sunday).
// stepping past 0001-01-01 or 9999-12-31 leaves the date unchanged.
//
// both channels use valid/ready. a request is taken only while the block is
// idle; it then walks through a small sequencer that shares one 14-bit adder:
// year step, a registered multiply for the divide by 100, the date update, one
// adder step per preceding month for the day of year, the adjusted year and its
// divide by 100, then one step for each of the five weekday terms and a mod 7
// fold. the result holds on the outputs while the receiver stalls and no new
// request is taken until it is delivered. a synchronous reset drops any
// request in flight and restores 0001-01-01.
`default_nettype none

module calendar_date_counter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [cdc_pkg::YEAR_W-1:0]  i_load_year,
    input  wire logic [cdc_pkg::MONTH_W-1:0] i_load_month,
    input  wire logic [cdc_pkg::DAY_W-1:0]   i_load_day,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [cdc_pkg::YEAR_W-1:0]       o_year_out,
    output logic [cdc_pkg::MONTH_W-1:0]      o_month_out,
    output logic [cdc_pkg::DAY_W-1:0]        o_day_out,
    output logic [cdc_pkg::ORD_W-1:0]        o_ordinal_day,
    output logic [cdc_pkg::WDAY_W-1:0]       o_weekday
);
    import cdc_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // request capture (payload, no reset)
    t_cmd                r_cmd;
    logic [YEAR_W-1:0]   r_ld_year;
    logic [MONTH_W-1:0]  r_ld_month;
    logic [DAY_W-1:0]    r_ld_day;

    // date state
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [YEAR_W-1:0]   n_year;
    logic [MONTH_W-1:0]  n_month;
    logic [DAY_W-1:0]    n_day;

    // work registers
    logic                r_roll;
    logic [QUOT_W-1:0]   r_q100;
    logic                r_leap;
    logic [ORD_W-1:0]    r_ord;
    logic [MONTH_W-1:0]  r_mcnt;
    logic [YEAR_W-1:0]   r_yy;
    logic [YEAR_W-1:0]   r_wsum;
    t_term               r_term;
    t_term               n_term;
    logic [WDAY_W-1:0]   r_weekday;

    logic [YEAR_W-1:0]   alu_a;
    logic [YEAR_W-1:0]   alu_b;
    logic                alu_sub;
    logic [YEAR_W-1:0]   alu_sum;

    logic                fwd_roll;
    logic                back_roll;
    logic [YEAR_W-1:0]   ld_year_cl;
    logic [MONTH_W-1:0]  ld_month_cl;
    logic [YEAR_W-1:0]   hundreds;
    logic                leap_now;
    logic [MONTH_W-1:0]  month_sel;
    logic [DAY_W-1:0]    len_sel;
    logic [YEAR_W-1:0]   term_val;

    logic [YEAR_W-1:0]   mul_in;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_sh;

    logic [4:0]          fold1;
    logic [3:0]          fold2;
    logic [WDAY_W-1:0]   wd_val;

    cdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    cdc_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    assign o_ready = ctrl.in_ready;
    assign o_valid = ctrl.out_valid;

    assign stat.ord_done  = (r_mcnt == r_month);
    assign stat.wsum_done = (r_term == TRM_DAY);

    // operand select for the shared adder
    always_comb begin
        alu_a   = r_wsum;
        alu_b   = term_val;
        alu_sub = 1'b0;
        case (ctrl.alu_op)
            AOP_YEAR: begin
                alu_a   = r_year;
                alu_b   = YEAR_MIN;
                alu_sub = (r_cmd == CMD_PREV);
            end
            AOP_ORD: begin
                alu_a = {{(YEAR_W-ORD_W){1'b0}}, r_ord};
                alu_b = {{(YEAR_W-DAY_W){1'b0}}, month_len(r_leap, r_mcnt)};
            end
            AOP_YY: begin
                alu_a   = r_year;
                alu_b   = YEAR_MIN;
                alu_sub = 1'b1;
            end
            AOP_WSUM: begin
                alu_a   = r_wsum;
                alu_b   = term_val;
                alu_sub = (r_term == TRM_CENT);
            end
            default: alu_sub = 1'b0;
        endcase
    end

    // divide by 100 through a constant reciprocal, registered below
    assign mul_in  = ctrl.div_src_yy ? r_yy : r_year;
    assign prod    = {{(PROD_W-YEAR_W){1'b0}}, mul_in} * {{(PROD_W-13){1'b0}}, DIV100_MUL};
    assign prod_sh = prod >> DIV100_SHIFT;

    // leap year from the year and its quotient by 100: 100 * q as shifts
    assign hundreds = {1'b0, r_q100, 6'b0} + {2'b0, r_q100, 5'b0}
                    + {{(YEAR_W-QUOT_W-2){1'b0}}, r_q100, 2'b0};
    assign leap_now = ((r_year[1:0] == 2'b00) && (r_year != hundreds))
                   || ((r_year == hundreds) && (r_q100[1:0] == 2'b00));

    // year step or load clamp
    always_comb begin
        if (r_ld_year < YEAR_MIN) begin
            ld_year_cl = YEAR_MIN;
        end else if (r_ld_year > YEAR_MAX) begin
            ld_year_cl = YEAR_MAX;
        end else begin
            ld_year_cl = r_ld_year;
        end
        fwd_roll  = (r_cmd == CMD_NEXT) && (r_month == MONTH_LAST)
                 && (r_day == DEC_LAST) && (r_year < YEAR_MAX);
        back_roll = (r_cmd == CMD_PREV) && (r_month == MONTH_FIRST)
                 && (r_day == DAY_FIRST) && (r_year > YEAR_MIN);
        if (r_cmd == CMD_LOAD) begin
            n_year = ld_year_cl;
        end else if (fwd_roll || back_roll) begin
            n_year = alu_sum;
        end else begin
            n_year = r_year;
        end
    end

    // month and day update, year already settled
    always_comb begin
        if (r_ld_month < MONTH_FIRST) begin
            ld_month_cl = MONTH_FIRST;
        end else if (r_ld_month > MONTH_LAST) begin
            ld_month_cl = MONTH_LAST;
        end else begin
            ld_month_cl = r_ld_month;
        end
        case (r_cmd)
            CMD_LOAD: month_sel = ld_month_cl;
            CMD_PREV: month_sel = r_month - MONTH_FIRST;
            default:  month_sel = r_month;
        endcase
        len_sel = month_len(leap_now, month_sel);
        n_month = r_month;
        n_day   = r_day;
        case (r_cmd)
            CMD_LOAD: begin
                n_month = ld_month_cl;
                if (r_ld_day < DAY_FIRST) begin
                    n_day = DAY_FIRST;
                end else if (r_ld_day > len_sel) begin
                    n_day = len_sel;
                end else begin
                    n_day = r_ld_day;
                end
            end
            CMD_NEXT: begin
                if (r_day < len_sel) begin
                    n_day = r_day + DAY_FIRST;
                end else if (r_month < MONTH_LAST) begin
                    n_month = r_month + MONTH_FIRST;
                    n_day   = DAY_FIRST;
                end else if (r_roll) begin
                    n_month = MONTH_FIRST;
                    n_day   = DAY_FIRST;
                end
            end
            CMD_PREV: begin
                if (r_day > DAY_FIRST) begin
                    n_day = r_day - DAY_FIRST;
                end else if (r_month > MONTH_FIRST) begin
                    n_month = month_sel;
                    n_day   = len_sel;
                end else if (r_roll) begin
                    n_month = MONTH_LAST;
                    n_day   = DEC_LAST;
                end
            end
            default: begin
                n_month = r_month;
                n_day   = r_day;
            end
        endcase
    end

    // weekday terms: yy/4, yy/100 (subtracted), yy/400, month term, day
    always_comb begin
        case (r_term)
            TRM_QUART: term_val = {2'b0, r_yy[YEAR_W-1:2]};
            TRM_CENT:  term_val = {{(YEAR_W-QUOT_W){1'b0}}, r_q100};
            TRM_QUAD:  term_val = {{(YEAR_W-QUOT_W+2){1'b0}}, r_q100[QUOT_W-1:2]};
            TRM_MONTH: term_val = {{(YEAR_W-6){1'b0}}, zeller_term(r_month)};
            TRM_DAY:   term_val = {{(YEAR_W-DAY_W){1'b0}}, r_day};
            default:   term_val = '0;
        endcase
        case (r_term)
            TRM_QUART: n_term = TRM_CENT;
            TRM_CENT:  n_term = TRM_QUAD;
            TRM_QUAD:  n_term = TRM_MONTH;
            TRM_MONTH: n_term = TRM_DAY;
            default:   n_term = TRM_DAY;
        endcase
    end

    // mod 7 by folding octal digits, since 8 is 1 mod 7
    always_comb begin
        fold1 = {2'b0, r_wsum[2:0]} + {2'b0, r_wsum[5:3]} + {2'b0, r_wsum[8:6]}
              + {2'b0, r_wsum[11:9]} + {3'b0, r_wsum[13:12]};
        fold2 = {1'b0, fold1[2:0]} + {2'b0, fold1[4:3]};
        if (fold2 >= 4'd7) begin
            wd_val = fold2[2:0] - 3'd7;
        end else begin
            wd_val = fold2[2:0];
        end
    end

    // date state, reset to 0001-01-01
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= YEAR_MIN;
            r_month <= MONTH_FIRST;
            r_day   <= DAY_FIRST;
        end else begin
            if (ctrl.year_we) begin
                r_year <= n_year;
            end
            if (ctrl.date_we) begin
                r_month <= n_month;
                r_day   <= n_day;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_valid) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_ld_year  <= i_load_year;
            r_ld_month <= i_load_month;
            r_ld_day   <= i_load_day;
        end
        if (ctrl.year_we) begin
            r_roll <= fwd_roll || back_roll;
        end
        if (ctrl.div_we) begin
            r_q100 <= prod_sh[QUOT_W-1:0];
        end
        if (ctrl.date_we) begin
            r_leap <= leap_now;
            r_ord  <= {{(ORD_W-DAY_W){1'b0}}, n_day};
            r_mcnt <= MONTH_FIRST;
        end
        if (ctrl.ord_we) begin
            r_ord  <= alu_sum[ORD_W-1:0];
            r_mcnt <= r_mcnt + MONTH_FIRST;
        end
        if (ctrl.yy_we) begin
            r_yy <= (r_month <= MONTH_FEB) ? alu_sum : r_year;
        end
        if (ctrl.wsum_init) begin
            r_wsum <= r_yy;
            r_term <= TRM_QUART;
        end
        if (ctrl.wsum_we) begin
            r_wsum <= alu_sum;
            r_term <= n_term;
        end
        if (ctrl.wd_we) begin
            r_weekday <= wd_val;
        end
    end

    assign o_year_out    = r_year;
    assign o_month_out   = r_month;
    assign o_day_out     = r_day;
    assign o_ordinal_day = r_ord;
    assign o_weekday     = r_weekday;

endmodule

`default_nettype wire

### test/tb_top.sv
// self-checking testbench for the calendar date counter
`default_nettype none

module tb_top;
    import cdc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 250;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [ORD_W-1:0]   ordinal;
        logic [WDAY_W-1:0]  wday;
    } t_date_result;

    // tracks the date the block should hold and the results still owed
    class date_scoreboard;
        int unsigned        cal_year;
        int unsigned        cal_month;
        int unsigned        cal_day;
        t_date_result       expected_dates[$];
        int                 errors;

        function new();
            cal_year  = 32'(YEAR_MIN);
            cal_month = 32'(MONTH_FIRST);
            cal_day   = 32'(DAY_FIRST);
            errors    = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in(int unsigned y, int unsigned m);
            int unsigned n;
            case (m)
                2:          n = is_leap(y) ? 29 : 28;
                4, 6, 9, 11: n = 30;
                default:    n = 31;
            endcase
            return n;
        endfunction

        function int unsigned year_ordinal(int unsigned y, int unsigned m, int unsigned d);
            int unsigned total;
            total = d;
            for (int unsigned i = 1; i < m; i++) begin
                total += days_in(y, i);
            end
            return total;
        endfunction

        // zeller style sum, january and february belong to the previous year
        function int unsigned week_index(int unsigned y, int unsigned m, int unsigned d);
            int unsigned yy;
            int unsigned mm;
            yy = y;
            mm = m;
            if (mm <= 2) begin
                yy = yy - 1;
                mm = mm + 12;
            end
            return (yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + d) % 7;
        endfunction

        function void note_request(t_cmd cmd, logic [YEAR_W-1:0] y,
                                   logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d);
            int unsigned  ly;
            int unsigned  lm;
            int unsigned  ld;
            t_date_result r;
            ly = 32'(y);
            lm = 32'(m);
            ld = 32'(d);
            case (cmd)
                CMD_LOAD: begin
                    if (ly < 32'(YEAR_MIN)) ly = 32'(YEAR_MIN);
                    if (ly > 32'(YEAR_MAX)) ly = 32'(YEAR_MAX);
                    if (lm < 1) lm = 1;
                    if (lm > 12) lm = 12;
                    if (ld < 1) ld = 1;
                    if (ld > days_in(ly, lm)) ld = days_in(ly, lm);
                    cal_year  = ly;
                    cal_month = lm;
                    cal_day   = ld;
                end
                CMD_NEXT: begin
                    if (cal_day < days_in(cal_year, cal_month)) begin
                        cal_day = cal_day + 1;
                    end else if (cal_month == 32'(MONTH_LAST)) begin
                        // the last day of year 9999 holds
                        if (cal_year != 32'(YEAR_MAX)) begin
                            cal_year  = cal_year + 1;
                            cal_month = 32'(MONTH_FIRST);
                            cal_day   = 32'(DAY_FIRST);
                        end
                    end else begin
                        cal_month = cal_month + 1;
                        cal_day   = 32'(DAY_FIRST);
                    end
                end
                CMD_PREV: begin
                    if (cal_day > 1) begin
                        cal_day = cal_day - 1;
                    end else if (cal_month == 32'(MONTH_FIRST)) begin
                        // the first day of year 1 holds
                        if (cal_year != 32'(YEAR_MIN)) begin
                            cal_year  = cal_year - 1;
                            cal_month = 32'(MONTH_LAST);
                            cal_day   = days_in(cal_year, cal_month);
                        end
                    end else begin
                        cal_month = cal_month - 1;
                        cal_day   = days_in(cal_year, cal_month);
                    end
                end
                default: begin
                end
            endcase
            r.year    = YEAR_W'(cal_year);
            r.month   = MONTH_W'(cal_month);
            r.day     = DAY_W'(cal_day);
            r.ordinal = ORD_W'(year_ordinal(cal_year, cal_month, cal_day));
            r.wday    = WDAY_W'(week_index(cal_year, cal_month, cal_day));
            expected_dates.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_date_result got);
            t_date_result want;
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d",
                                          got.year, got.month, got.day));
            end else begin
                want = expected_dates.pop_front();
                if (got.year !== want.year)
                    report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
                if (got.month !== want.month)
                    report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
                if (got.day !== want.day)
                    report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
                if (got.ordinal !== want.ordinal)
                    report_mismatch($sformatf("ordinal %0d, want %0d",
                                              got.ordinal, want.ordinal));
                if (got.wday !== want.wday)
                    report_mismatch($sformatf("weekday %0d, want %0d", got.wday, want.wday));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_cmd = CMD_QUERY;
    logic [YEAR_W-1:0]    i_load_year = '0;
    logic [MONTH_W-1:0]   i_load_month = '0;
    logic [DAY_W-1:0]     i_load_day = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [YEAR_W-1:0]    o_year_out;
    logic [MONTH_W-1:0]   o_month_out;
    logic [DAY_W-1:0]     o_day_out;
    logic [ORD_W-1:0]     o_ordinal_day;
    logic [WDAY_W-1:0]    o_weekday;

    date_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_req_cnt = 0;
    int             hold_seen = 0;
    int             hold_left = 0;
    int             cycle_count = 0;
    int unsigned    corner_years [11] = '{1, 2, 399, 400, 1899, 1900, 2000, 2100, 2400,
                                         9998, 9999};

    calendar_date_counter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_load_year   (i_load_year),
        .i_load_month  (i_load_month),
        .i_load_day    (i_load_day),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_year_out    (o_year_out),
        .o_month_out   (o_month_out),
        .o_day_out     (o_day_out),
        .o_ordinal_day (o_ordinal_day),
        .o_weekday     (o_weekday)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor, samples the values present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            sb.check_result('{o_year_out, o_month_out, o_day_out, o_ordinal_day, o_weekday});
        end
    end

    // offers one request after a random idle gap and returns at its accepting edge
    task send_request(t_cmd cmd, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                      logic [DAY_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_load_year  <= y;
        i_load_month <= m;
        i_load_day   <= d;
        do begin
            @(posedge i_clk);
        end while (o_ready !== 1'b1);
        sb.note_request(cmd, y, m, d);
    endtask

    // sender pause until every owed result is back, then let the block settle
    task wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly day steps and some loads, often near month ends, some out of range
    function void rand_request(output t_cmd cmd, output logic [YEAR_W-1:0] y,
                               output logic [MONTH_W-1:0] m, output logic [DAY_W-1:0] d);
        int unsigned pick;
        pick = $urandom_range(99);
        y    = YEAR_W'($urandom);
        m    = MONTH_W'($urandom);
        d    = DAY_W'($urandom);
        if (pick < 20) begin
            cmd = CMD_LOAD;
            pick = $urandom_range(99);
            if (pick < 40) y = YEAR_W'(corner_years[$urandom_range(10)]);
            else if (pick < 80) y = YEAR_W'($urandom_range(9999, 1));
            if ($urandom_range(99) < 85) m = MONTH_W'($urandom_range(12, 1));
            if ($urandom_range(99) < 60) d = DAY_W'($urandom_range(31, 27));
        end else if (pick < 60) begin
            cmd = CMD_NEXT;
        end else if (pick < 90) begin
            cmd = CMD_PREV;
        end else begin
            cmd = CMD_QUERY;
        end
    endfunction

    initial begin
        t_cmd               c;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset date, both calendar ends, clamping, leap rules
        send_request(CMD_QUERY, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_LOAD, 14'd9999, 4'd12, 5'd31);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_LOAD, 14'd0, 4'd0, 5'd0);
        send_request(CMD_LOAD, 14'h3fff, 4'hf, 5'h1f);
        send_request(CMD_LOAD, 14'd2000, 4'd2, 5'd31);
        send_request(CMD_LOAD, 14'd1900, 4'd2, 5'd29);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_LOAD, 14'd2024, 4'd2, 5'd28);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_LOAD, 14'd2023, 4'd12, 5'd31);
        send_request(CMD_NEXT, '0, '0, '0);
        send_request(CMD_PREV, '0, '0, '0);
        send_request(CMD_LOAD, 14'd2021, 4'd4, 5'd31);
        send_request(CMD_LOAD, 14'd2000, 4'd13, 5'd15);
        send_request(CMD_LOAD, 14'd10000, 4'd6, 5'd0);
        send_request(CMD_QUERY, 14'h3fff, 4'hf, 5'h1f);
        send_request(CMD_LOAD, 14'd1, 4'd1, 5'd1);
        wait_drained();

        // random phases: no idling, idle sender, stalling receiver, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold-off while requests keep coming
                if (phase == 0 && k == 100) hold_req_cnt = hold_req_cnt + 1;
                if (k == 180) wait_drained();
                rand_request(c, y, m, d);
                send_request(c, y, m, d);
            end
            wait_drained();
        end

        if (sb.expected_dates.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_dates.size()));
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/cdc_pkg.sv
rtl/cdc_alu.sv
rtl/cdc_ctrl.sv
rtl/calendar_date_counter.sv
test/tb_top.sv
